>>> rtl/pnm_header_parser_top_macros.svh
// Assertion macros used by the PNM header parser top.
// Standalone header; no dependencies.
`ifndef PNM_HEADER_PARSER_TOP_MACROS_SVH
`define PNM_HEADER_PARSER_TOP_MACROS_SVH

// Check a condition that must hold in the same cycle as the trigger.
`define PNM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pnm header parser: same-cycle check failed");

// Check a condition that must hold in the cycle after the trigger.
`define PNM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pnm header parser: next-cycle check failed");

`endif

>>> rtl/pnm_hdr_pkg.sv
// Types, codes and character helpers for the PNM header parser.
// No dependencies.
package pnm_hdr_pkg;

    typedef enum logic [3:0] {
        MODE_MAGIC   = 4'b0001,
        MODE_COMMENT = 4'b0010,
        MODE_SPACE   = 4'b0100,
        MODE_NUMBER  = 4'b1000
    } parse_mode_t;

    localparam logic [1:0] ST_PARSING  = 2'd0;
    localparam logic [1:0] ST_DONE     = 2'd1;
    localparam logic [1:0] ST_BADCHAR  = 2'd2;
    localparam logic [1:0] ST_BADMAGIC = 2'd3;

    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_P       = 8'h50;
    localparam logic [7:0] CHAR_ONE     = 8'h31;
    localparam logic [7:0] CHAR_SIX     = 8'h36;

    localparam int RESULT_BITS = 55;
    localparam int TDATA_BITS  = 56;

    // Declared high field first so that status lands in the low bits.
    typedef struct packed {
        logic        wide_samples;
        logic        binary_format;
        logic [2:0]  format_number;
        logic [15:0] max_value;
        logic [15:0] height;
        logic [15:0] width;
        logic [1:0]  status;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || (c inside {[8'd9:8'd13]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'd48:8'd57]};
    endfunction

endpackage

>>> rtl/pnm_hdr_core.sv
// Parse state of the PNM header parser and the per-beat update logic.
// Depends on pnm_hdr_pkg.
module pnm_hdr_core import pnm_hdr_pkg::*; #(
    parameter int NUMBER_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        beat_fire,
    input  logic [7:0]  beat_byte,
    input  logic        beat_sof,
    output result_t     result_next
);

    localparam int PROD_BITS = NUMBER_BITS + 4;
    localparam logic [PROD_BITS-1:0] LIMIT = {4'b0, {NUMBER_BITS{1'b1}}};

    parse_mode_t            mode_reg, mode_next, mode_base;
    logic [1:0]             status_reg, status_next, status_base;
    logic [1:0]             count_reg, count_next, count_base;
    logic [1:0]             nread_reg, nread_next, nread_base;
    logic [7:0]             magic0_reg, magic0_next;
    logic [7:0]             magic1_reg, magic1_next;
    logic [NUMBER_BITS-1:0] accum_reg, accum_next;
    logic [NUMBER_BITS-1:0] width_reg, width_next;
    logic [NUMBER_BITS-1:0] height_reg, height_next;
    logic [NUMBER_BITS-1:0] maxval_reg, maxval_next;

    logic [PROD_BITS-1:0]   prod;
    logic                   finish;
    logic                   magic_ok;
    logic [7:0]             digit_byte;
    logic [NUMBER_BITS+15:0] width_ext, height_ext, maxval_ext;

    always_comb begin
        // start of file clears the control state before the byte is handled
        mode_base   = beat_sof ? MODE_MAGIC : mode_reg;
        status_base = beat_sof ? ST_PARSING : status_reg;
        count_base  = beat_sof ? 2'd0 : count_reg;
        nread_base  = beat_sof ? 2'd0 : nread_reg;

        mode_next   = mode_base;
        status_next = status_base;
        count_next  = count_base;
        nread_next  = nread_base;
        magic0_next = magic0_reg;
        magic1_next = magic1_reg;
        accum_next  = accum_reg;
        width_next  = width_reg;
        height_next = height_reg;
        maxval_next = maxval_reg;
        finish      = 1'b0;

        prod = ({4'b0, accum_reg} << 3) + ({4'b0, accum_reg} << 1)
             + {{NUMBER_BITS{1'b0}}, beat_byte[3:0]};

        if (status_base == ST_PARSING) begin
            case (mode_base)
                MODE_MAGIC: begin
                    if (beat_byte == CHAR_HASH) begin
                        mode_next = MODE_COMMENT;
                    end else if (is_ws(beat_byte)) begin
                        mode_next = MODE_SPACE;
                    end else begin
                        if (count_base == 2'd0) begin
                            magic0_next = beat_byte;
                        end else if (count_base == 2'd1) begin
                            magic1_next = beat_byte;
                        end
                        if (count_base != 2'd3) begin
                            count_next = count_base + 2'd1;
                        end
                    end
                end
                MODE_COMMENT: begin
                    if (beat_byte == CHAR_NEWLINE) begin
                        mode_next = MODE_SPACE;
                    end
                end
                MODE_SPACE: begin
                    if (!is_ws(beat_byte)) begin
                        if (beat_byte == CHAR_HASH) begin
                            mode_next = MODE_COMMENT;
                        end else if (is_digit(beat_byte)) begin
                            accum_next = {{(NUMBER_BITS-4){1'b0}}, beat_byte[3:0]};
                            mode_next  = MODE_NUMBER;
                        end else begin
                            status_next = ST_BADCHAR;
                        end
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(beat_byte)) begin
                        accum_next = (prod > LIMIT) ? {NUMBER_BITS{1'b1}}
                                                    : prod[NUMBER_BITS-1:0];
                    end else if (beat_byte == CHAR_HASH) begin
                        mode_next = MODE_COMMENT;
                        finish    = 1'b1;
                    end else if (is_ws(beat_byte)) begin
                        mode_next = MODE_SPACE;
                        finish    = 1'b1;
                    end else begin
                        status_next = ST_BADCHAR;
                    end
                end
                default: begin
                    mode_next = MODE_MAGIC;
                end
            endcase
        end

        magic_ok = (count_base == 2'd2) && (magic0_reg == CHAR_P) &&
                   (magic1_reg >= CHAR_ONE) && (magic1_reg <= CHAR_SIX);

        if (finish) begin
            accum_next = '0;
            nread_next = nread_base + 2'd1;
            case (nread_base)
                2'd0:    width_next  = accum_reg;
                2'd1:    height_next = accum_reg;
                default: begin
                    maxval_next = accum_reg;
                    status_next = magic_ok ? ST_DONE : ST_BADMAGIC;
                end
            endcase
        end
    end

    // result fields follow the updated state; all but status are zero unless done
    always_comb begin
        width_ext  = {16'b0, width_next};
        height_ext = {16'b0, height_next};
        maxval_ext = {16'b0, maxval_next};
        digit_byte = magic1_next - CHAR_ZERO;

        result_next        = '0;
        result_next.status = status_next;
        if (status_next == ST_DONE) begin
            result_next.width         = width_ext[15:0];
            result_next.height        = height_ext[15:0];
            result_next.max_value     = maxval_ext[15:0];
            result_next.format_number = digit_byte[2:0];
            result_next.binary_format = (digit_byte[2:0] >= 3'd4);
            result_next.wide_samples  = (maxval_ext >= (NUMBER_BITS+16)'(256));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_MAGIC;
            status_reg <= ST_PARSING;
            count_reg  <= 2'd0;
            nread_reg  <= 2'd0;
        end else if (beat_fire) begin
            mode_reg   <= mode_next;
            status_reg <= status_next;
            count_reg  <= count_next;
            nread_reg  <= nread_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_fire) begin
            magic0_reg <= magic0_next;
            magic1_reg <= magic1_next;
            accum_reg  <= accum_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            maxval_reg <= maxval_next;
        end
    end

endmodule

>>> rtl/pnm_header_parser_top.sv
// PNM header parser: s_ beat -> input register -> parse logic -> result register
// -> m_ beat; throughput one byte per cycle while m_tready does not stall it.
// Every accepted byte yields one result beat carrying the current status.
// aresetn (synchronous, active low) empties both stages and returns the parser
// to the start of a header; s_tuser restarts parsing on its own beat.
// Depends on pnm_hdr_pkg, pnm_hdr_core and pnm_header_parser_top_macros.svh.
`include "pnm_header_parser_top_macros.svh"

module pnm_header_parser_top import pnm_hdr_pkg::*; #(
    parameter int NUMBER_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] byte_in
    input  logic                  s_tuser,   // start_of_file
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] status, [17:2] width, [33:18] height, [49:34] max_value,
    // [52:50] format_number, [53] binary_format, [54] wide_samples, [55] zero
    output logic [TDATA_BITS-1:0] m_tdata
);

    // input stage: holds one beat until the result register can take it
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_sof_reg;

    // result stage
    logic       out_valid_reg, out_valid_next;
    result_t    out_data_reg;
    result_t    result_next;

    logic       advance;
    logic       fire;
    logic       s_fire;

    // short views of the stages for the checks below
    logic       in_stall;
    logic [8:0] in_beat;
    logic       m_done;
    logic       m_not_done;
    logic [2:0] m_format;

    // advance the input beat whenever the result register is free or draining
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    assign in_valid_next  = s_fire || (in_valid_reg && !advance);
    assign out_valid_next = fire || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture payload only on an accepted beat; hold it otherwise
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
            in_sof_reg  <= s_tuser;
        end
        if (fire) begin
            out_data_reg <= result_next;
        end
    end

    // parse state and per-byte update
    pnm_hdr_core #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_fire   (fire),
        .beat_byte   (in_byte_reg),
        .beat_sof    (in_sof_reg),
        .result_next (result_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_BITS-RESULT_BITS){1'b0}}, out_data_reg};

    assign in_stall   = in_valid_reg && !advance;
    assign in_beat    = {in_sof_reg, in_byte_reg};
    assign m_done     = m_tvalid && (m_tdata[1:0] == ST_DONE);
    assign m_not_done = m_tvalid && (m_tdata[1:0] != ST_DONE);
    assign m_format   = m_tdata[52:50];

    // header fields only appear alongside a done status
    `PNM_ASSERT_NOW(a_fields_zero_unless_done, aclk, aresetn, m_not_done, m_tdata[55:2] == '0)
    // a done header always carries a magic digit of one to six
    `PNM_ASSERT_NOW(a_done_has_format, aclk, aresetn, m_done, (m_format != 3'd0) && (m_format <= 3'd6))
    // a stalled input beat stays in the input register
    `PNM_ASSERT_NEXT(a_input_stage_holds, aclk, aresetn, in_stall, in_valid_reg && $stable(in_beat))
    // every beat that leaves the input stage shows up as a result beat
    `PNM_ASSERT_NEXT(a_fire_gives_result, aclk, aresetn, fire, m_tvalid)

endmodule
